// ===== hw/rtl/bcdc_pkg.sv =====
// ----------------------------------------------------------------------------
// BCD clock block package
// Shared types, calendar constants and BCD helper functions.
// ----------------------------------------------------------------------------
package bcdc_pkg;

   // Days from 1900-01-01 to 1970-01-01, plus one so that day 1 maps to offset 0.
   localparam logic signed [17:0] EPOCH_BIAS_DAYS = 18'sd25568;

   // Seconds in one day.
   localparam logic signed [17:0] SEC_PER_DAY = 18'sd86400;

   // Years added to 1900 when the century byte is one.
   localparam logic [7:0] CENTURY_YEARS = 8'd100;

   // Decoded beat passed from the decode stage to the scale stage.
   typedef struct packed {
      logic               bad;
      logic signed [17:0] days;
      logic [16:0]        sod;
   } bcdc_dec_type;

   // True when both nibbles of a byte are decimal digits.
   function automatic logic bcd_ok(input logic [7:0] b);
      return (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
   endfunction

   // Binary value of a BCD byte; only meaningful when bcd_ok holds.
   function automatic logic [6:0] bcd_value(input logic [7:0] b);
      logic [7:0] t;
      t = ({4'd0, b[7:4]} << 3) + ({4'd0, b[7:4]} << 1) + {4'd0, b[3:0]};
      return t[6:0];
   endfunction

   // Day of year at which a month starts, in a common year (month 1..12).
   function automatic logic [8:0] month_start_days(input logic [3:0] m);
      logic [8:0] d;
      unique case (m)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

// ===== hw/rtl/bcd_clock_block_to_epoch.sv =====
// ----------------------------------------------------------------------------
// BCD clock block to epoch seconds
// Checks an eight-byte BCD clock block and converts it to signed seconds
// since 1970-01-01 00:00:00 UTC.
// ----------------------------------------------------------------------------
// The block takes one clock block in every cycle: busy is always low, so a
// beat is accepted at every rising edge with start high. The result appears
// on the rsp_ ports, marked by rsp_valid, for exactly one cycle, in the order
// the blocks were taken. The result passes three register stages: the input
// register, the decode register after field checks and day counting, and the
// result register after the multiply by seconds per day. The receiver cannot
// stall the block, and none of the stages ever holds a beat back. A bad block
// gives rsp_status high and rsp_epoch_seconds zero.
// ----------------------------------------------------------------------------
module bcd_clock_block_to_epoch (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [63:0]        req_time_block,
   output logic               rsp_valid,
   output logic               rsp_status,
   output logic signed [32:0] rsp_epoch_seconds
);

   logic                   in_valid_ff;
   logic [63:0]            in_block_ff;
   logic                   dec_valid_ff;
   bcdc_pkg::bcdc_dec_type dec_ff;
   bcdc_pkg::bcdc_dec_type dec_in;
   logic                   rsp_valid_ff;
   logic                   rsp_status_ff;
   logic signed [32:0]     rsp_secs_ff;
   logic                   rsp_status_in;
   logic signed [32:0]     rsp_secs_in;

   // The pipeline never stalls.
   assign busy = 1'b0;

   // Field checks and calendar arithmetic.
   bcdc_decode u_decode (
      .time_block (in_block_ff),
      .dec        (dec_in)
   );

   // Day count to seconds.
   bcdc_scale u_scale (
      .dec           (dec_ff),
      .status        (rsp_status_in),
      .epoch_seconds (rsp_secs_in)
   );

   // Valid bits of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         dec_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= start && !busy;
         dec_valid_ff <= in_valid_ff;
         rsp_valid_ff <= dec_valid_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_block_ff   <= req_time_block;
      dec_ff        <= dec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_secs_ff   <= rsp_secs_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_epoch_seconds = rsp_secs_ff;

   // A decoded beat always reaches the result port in the next cycle.
   a_dec_to_rsp: assert property (@(posedge clock) disable iff (reset)
      dec_valid_ff |=> rsp_valid)
      else $error("decoded beat did not reach the result port");

   // A bad block reports zero seconds.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_epoch_seconds == 33'sd0)
      else $error("bad block with nonzero seconds");

   // A good block stays within 1900-01-01 .. 2099-12-31 23:59:59.
   a_good_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_status |->
         (rsp_epoch_seconds >= -33'sd2208988800) &&
         (rsp_epoch_seconds <= 33'sd4102444799))
      else $error("epoch seconds out of range");

endmodule

// ===== hw/rtl/bcdc_decode.sv =====
// ----------------------------------------------------------------------------
// BCD clock block decode
// Checks every field of the clock block and reduces the date to a signed day
// count from 1970-01-01 and the time of day to seconds.
// ----------------------------------------------------------------------------
module bcdc_decode (
   input  logic [63:0]           time_block,
   output bcdc_pkg::bcdc_dec_type dec
);

   logic [7:0]  b_sec, b_min, b_hour, b_day, b_wday, b_mon, b_year, b_cent;
   logic [6:0]  v_sec, v_min, v_hour, v_day, v_wday, v_mon, v_year, v_cent;
   logic        digits_ok;
   logic        range_bad;
   logic [7:0]  year_ofs;
   logic [7:0]  year_ofs_m1;
   logic [16:0] year_days;
   logic [5:0]  leaps;
   logic        leap_year;
   logic        leap_adj;
   logic [16:0] pos_days;

   // Split the block into bytes; the hour marker bit is dropped from the hour.
   always_comb begin
      b_sec  = time_block[7:0];
      b_min  = time_block[15:8];
      b_hour = {1'b0, time_block[22:16]};
      b_day  = time_block[31:24];
      b_wday = time_block[39:32];
      b_mon  = time_block[47:40];
      b_year = time_block[55:48];
      b_cent = time_block[63:56];
   end

   // Convert every byte from BCD.
   always_comb begin
      v_sec  = bcdc_pkg::bcd_value(b_sec);
      v_min  = bcdc_pkg::bcd_value(b_min);
      v_hour = bcdc_pkg::bcd_value(b_hour);
      v_day  = bcdc_pkg::bcd_value(b_day);
      v_wday = bcdc_pkg::bcd_value(b_wday);
      v_mon  = bcdc_pkg::bcd_value(b_mon);
      v_year = bcdc_pkg::bcd_value(b_year);
      v_cent = bcdc_pkg::bcd_value(b_cent);
   end

   // Field checks.
   always_comb begin
      digits_ok = bcdc_pkg::bcd_ok(b_sec) && bcdc_pkg::bcd_ok(b_min) &&
                  bcdc_pkg::bcd_ok(b_hour) && bcdc_pkg::bcd_ok(b_day) &&
                  bcdc_pkg::bcd_ok(b_wday) && bcdc_pkg::bcd_ok(b_mon) &&
                  bcdc_pkg::bcd_ok(b_year) && bcdc_pkg::bcd_ok(b_cent);
      range_bad = (v_cent > 7'd1) || (v_mon == 7'd0) || (v_mon > 7'd12) ||
                  (v_day == 7'd0) || (v_day > 7'd31) || (v_wday > 7'd6) ||
                  (v_hour >= 7'd24) || (v_min >= 7'd60) || (v_sec >= 7'd60);
   end

   // Years since 1900 and the days before January 1 of that year.
   // Within 1900..2099 the only century year is 1900 (not leap) and 2000 (leap),
   // so a leap year is simply a nonzero multiple of four.
   always_comb begin
      year_ofs    = {1'b0, v_year} + (v_cent[0] ? bcdc_pkg::CENTURY_YEARS : 8'd0);
      year_ofs_m1 = year_ofs - 8'd1;
      year_days   = ({9'd0, year_ofs} << 8) + ({9'd0, year_ofs} << 6) +
                    ({9'd0, year_ofs} << 5) + ({9'd0, year_ofs} << 3) +
                    ({9'd0, year_ofs} << 2) + {9'd0, year_ofs};
      leaps       = (year_ofs == 8'd0) ? 6'd0 : year_ofs_m1[7:2];
      leap_year   = (year_ofs[1:0] == 2'd0) && (year_ofs != 8'd0);
      leap_adj    = (v_mon > 7'd2) && leap_year;
      pos_days    = year_days + {11'd0, leaps} +
                    {8'd0, bcdc_pkg::month_start_days(v_mon[3:0])} +
                    {16'd0, leap_adj} + {12'd0, v_day[4:0]};
   end

   // Pack the beat for the scale stage.
   always_comb begin
      dec.bad  = (time_block == 64'd0) || !time_block[23] || !digits_ok || range_bad;
      dec.days = $signed({1'b0, pos_days}) - bcdc_pkg::EPOCH_BIAS_DAYS;
      dec.sod  = ({10'd0, v_hour} * 17'd3600) + ({10'd0, v_min} * 17'd60) +
                 {10'd0, v_sec};
   end

endmodule

// ===== hw/rtl/bcdc_scale.sv =====
// ----------------------------------------------------------------------------
// BCD clock block scale
// Turns the signed day count and the second of the day into epoch seconds,
// or zero for a bad block.
// ----------------------------------------------------------------------------
module bcdc_scale (
   input  bcdc_pkg::bcdc_dec_type dec,
   output logic                   status,
   output logic signed [32:0]     epoch_seconds
);

   logic signed [35:0] day_secs;
   logic signed [35:0] total;

   // One 18 by 18 signed multiply, then add the time of day.
   always_comb begin
      day_secs      = 36'(dec.days) * 36'(bcdc_pkg::SEC_PER_DAY);
      total         = day_secs + $signed({19'd0, dec.sod});
      status        = dec.bad;
      epoch_seconds = dec.bad ? 33'sd0 : $signed(total[32:0]);
   end

endmodule
